// ===== design/vks_pkg.sv =====
// Package for the vector keyframe sampler.
// Holds table sizes, controller commands and the controller/datapath structs.
// No dependencies.
package vks_pkg;

  localparam int unsigned MaxKeys = 256;
  localparam int unsigned KeyAw   = $clog2(MaxKeys);
  localparam int unsigned CountW  = KeyAw + 1;

  localparam logic [16:0] AlphaOne = 17'h10000;

  // Input function codes.
  localparam logic FuncLoad   = 1'b0;
  localparam logic FuncSample = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_RD0, S_SEARCH, S_PROBE, S_END, S_LAST,
    S_RDB, S_RDA, S_DIV, S_MUL, S_ADD, S_OUT
  } state_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_START, OP_RES_ZERO, OP_RES_KEY0, OP_RES_LAST, OP_PROBE,
    OP_LATCH_B, OP_LATCH_A, OP_DIV_STEP, OP_MUL, OP_ADD
  } op_e;

  // Table read address sources.
  typedef enum logic [2:0] {
    RA_ZERO, RA_PROBE, RA_LAST, RA_LO, RA_A
  } raddr_e;

  typedef struct packed {
    logic   wr;
    op_e    op;
    raddr_e ra;
    logic [1:0] comp;
  } vks_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic early;
    logic count_zero;
    logic lo_ge_n;
    logic span_zero;
    logic div_full;
  } vks_sts_t;

endpackage

// ===== design/vector_keyframe_sampler.sv =====
// Vector keyframe sampler: a load transaction writes the key table and the block stays
// ready for the next input. A sample's result transaction follows a binary search (up
// to eight probes for a full table), up to 16 restoring division steps for alpha and
// a multiply and add per component on the shared lerp multiplier. One item is in work
// at a time; the next input is taken in the cycle after the result transaction.
// Reset clears the key count and the controller; the key table is not reset.
module vector_keyframe_sampler import vks_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [7:0]         key_index_i,
  input  logic [31:0]        key_time_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  input  logic [31:0]        sample_time_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [8:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [7:0]         from_index_o,
  output logic [7:0]         to_index_o,
  output logic               indices_valid_o,
  output logic [16:0]        alpha_o
);

  vks_cmd_t cmd;
  vks_sts_t sts;

  // The key count register takes every write transaction at once.
  assign cfg_ready_o = 1'b1;

  vks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vks_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .key_index_i     (key_index_i),
    .key_time_i      (key_time_i),
    .value_x_i       (value_x_i),
    .value_y_i       (value_y_i),
    .value_z_i       (value_z_i),
    .sample_time_i   (sample_time_i),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_z_o         (out_z_o),
    .from_index_o    (from_index_o),
    .to_index_o      (to_index_o),
    .indices_valid_o (indices_valid_o),
    .alpha_o         (alpha_o)
  );

endmodule

// ===== design/vks_ctrl.sv =====
// Controller state machine of the vector keyframe sampler.
// Sequences search, division and interpolation; depends on vks_pkg.
module vks_ctrl import vks_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     func_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  vks_sts_t sts_i,
  output vks_cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [1:0] comp_q, comp_d;

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      comp_q  <= comp_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    comp_d      = comp_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.wr    = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.ra    = RA_ZERO;
    cmd_o.comp  = comp_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (func_i == FuncLoad) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.op = OP_START;
            state_d  = S_START;
          end
        end
      end
      S_START: begin
        cmd_o.ra = RA_ZERO;
        if (sts_i.n_zero) begin
          cmd_o.op = OP_RES_ZERO;
          state_d  = S_OUT;
        end else begin
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        if (sts_i.early) begin
          cmd_o.op = OP_RES_KEY0;
          state_d  = S_OUT;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.ra = RA_PROBE;
        state_d  = sts_i.count_zero ? S_END : S_PROBE;
      end
      S_PROBE: begin
        cmd_o.op = OP_PROBE;
        state_d  = S_SEARCH;
      end
      S_END: begin
        if (sts_i.lo_ge_n) begin
          cmd_o.ra = RA_LAST;
          state_d  = S_LAST;
        end else begin
          cmd_o.ra = RA_LO;
          state_d  = S_RDB;
        end
      end
      S_LAST: begin
        cmd_o.op = OP_RES_LAST;
        state_d  = S_OUT;
      end
      S_RDB: begin
        cmd_o.op = OP_LATCH_B;
        cmd_o.ra = RA_A;
        state_d  = S_RDA;
      end
      S_RDA: begin
        cmd_o.op = OP_LATCH_A;
        comp_d   = '0;
        step_d   = '0;
        if (sts_i.span_zero) begin
          state_d = S_OUT;
        end else if (sts_i.div_full) begin
          state_d = S_MUL;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        step_d   = step_q + 4'd1;
        if (step_q == 4'd15) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_ADD;
      end
      S_ADD: begin
        cmd_o.op = OP_ADD;
        if (comp_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/vks_dp.sv =====
// Datapath of the vector keyframe sampler: key table memories, search
// registers, restoring divider for alpha and a shared lerp multiplier.
// Depends on vks_pkg.
module vks_dp import vks_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vks_cmd_t            cmd_i,
  output vks_sts_t            sts_o,
  input  logic                cfg_valid_i,
  input  logic [CountW-1:0]   cfg_data_i,
  input  logic [KeyAw-1:0]    key_index_i,
  input  logic [31:0]         key_time_i,
  input  logic signed [31:0]  value_x_i,
  input  logic signed [31:0]  value_y_i,
  input  logic signed [31:0]  value_z_i,
  input  logic [31:0]         sample_time_i,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o,
  output logic [7:0]          from_index_o,
  output logic [7:0]          to_index_o,
  output logic                indices_valid_o,
  output logic [16:0]         alpha_o
);

  logic [31:0] times_mem [MaxKeys];
  logic [95:0] vecs_mem  [MaxKeys];

  logic [CountW-1:0] key_count_q;
  logic [31:0]       rd_time_q;
  logic [95:0]       rd_vec_q;
  logic [KeyAw-1:0]  rd_addr;

  logic [31:0]       t_q;
  logic [CountW-1:0] n_q, lo_q, count_q;
  logic [CountW-1:0] probe, step, n_eff;
  logic [31:0]       tb_q, range_q, rem_q;
  logic [95:0]       vb_q, va_q, res_q;
  logic [KeyAw-1:0]  from_q, to_q;
  logic              valid_q;
  logic [16:0]       alpha_q;
  logic signed [49:0] prod_q;

  logic [31:0]       num, range_new;
  logic [32:0]       rem2;
  logic signed [32:0] diff;
  logic signed [49:0] rsum;
  logic [31:0]       va_c, vb_c;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (cfg_valid_i) begin
      key_count_q <= cfg_data_i;
    end
  end

  // Read address selection.
  assign step  = {1'b0, count_q[CountW-1:1]};
  assign probe = lo_q + step;
  always_comb begin
    case (cmd_i.ra)
      RA_ZERO:  rd_addr = '0;
      RA_PROBE: rd_addr = probe[KeyAw-1:0];
      RA_LAST:  rd_addr = n_q[KeyAw-1:0] - 1'b1;
      RA_LO:    rd_addr = lo_q[KeyAw-1:0];
      RA_A:     rd_addr = lo_q[KeyAw-1:0] - 1'b1;
      default:  rd_addr = '0;
    endcase
  end

  // Key table: one write port, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      times_mem[key_index_i] <= key_time_i;
      vecs_mem[key_index_i]  <= {value_z_i, value_y_i, value_x_i};
    end
    rd_time_q <= times_mem[rd_addr];
    rd_vec_q  <= vecs_mem[rd_addr];
  end

  // Span arithmetic on the freshly read earlier key.
  assign num       = (t_q > rd_time_q) ? (t_q - rd_time_q) : '0;
  assign range_new = tb_q - rd_time_q;
  assign rem2      = {rem_q, 1'b0};
  assign n_eff     = (key_count_q > CountW'(MaxKeys)) ? CountW'(MaxKeys) : key_count_q;

  assign va_c = va_q[32*cmd_i.comp +: 32];
  assign vb_c = vb_q[32*cmd_i.comp +: 32];
  assign diff = $signed({vb_c[31], vb_c}) - $signed({va_c[31], va_c});
  assign rsum = (prod_q + 50'sd32768) >>> 16;

  // Status toward the controller.
  always_comb begin
    sts_o.n_zero     = (n_q == '0);
    sts_o.early      = (n_q == CountW'(1)) || (t_q <= rd_time_q);
    sts_o.count_zero = (count_q == '0);
    sts_o.lo_ge_n    = (lo_q >= n_q);
    sts_o.span_zero  = (tb_q <= rd_time_q);
    sts_o.div_full   = (num >= range_new);
  end

  // Search, division and interpolation registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        t_q     <= sample_time_i;
        n_q     <= n_eff;
        lo_q    <= CountW'(1);
        count_q <= n_eff - 1'b1;
      end
      OP_RES_ZERO: begin
        res_q   <= '0;
        from_q  <= '0;
        to_q    <= '0;
        valid_q <= 1'b0;
        alpha_q <= '0;
      end
      OP_RES_KEY0: begin
        res_q   <= rd_vec_q;
        from_q  <= '0;
        to_q    <= '0;
        valid_q <= 1'b1;
        alpha_q <= '0;
      end
      OP_RES_LAST: begin
        res_q   <= rd_vec_q;
        from_q  <= n_q[KeyAw-1:0] - 1'b1;
        to_q    <= n_q[KeyAw-1:0] - 1'b1;
        valid_q <= 1'b1;
        alpha_q <= '0;
      end
      OP_PROBE: begin
        if (rd_time_q < t_q) begin
          lo_q    <= probe + 1'b1;
          count_q <= count_q - step - 1'b1;
        end else begin
          count_q <= step;
        end
      end
      OP_LATCH_B: begin
        tb_q <= rd_time_q;
        vb_q <= rd_vec_q;
      end
      OP_LATCH_A: begin
        va_q    <= rd_vec_q;
        from_q  <= lo_q[KeyAw-1:0] - 1'b1;
        to_q    <= lo_q[KeyAw-1:0];
        valid_q <= 1'b1;
        range_q <= range_new;
        rem_q   <= num;
        if (tb_q <= rd_time_q) begin
          res_q   <= vb_q;
          alpha_q <= AlphaOne;
        end else if (num >= range_new) begin
          alpha_q <= AlphaOne;
        end else begin
          alpha_q <= '0;
        end
      end
      OP_DIV_STEP: begin
        if (rem2 >= {1'b0, range_q}) begin
          rem_q   <= 32'(rem2 - {1'b0, range_q});
          alpha_q <= {alpha_q[15:0], 1'b1};
        end else begin
          rem_q   <= rem2[31:0];
          alpha_q <= {alpha_q[15:0], 1'b0};
        end
      end
      OP_MUL: begin
        prod_q <= 50'(diff * $signed({1'b0, alpha_q}));
      end
      OP_ADD: begin
        res_q[32*cmd_i.comp +: 32] <= va_c + rsum[31:0];
      end
      default: begin
      end
    endcase
  end

  assign out_x_o         = res_q[31:0];
  assign out_y_o         = res_q[63:32];
  assign out_z_o         = res_q[95:64];
  assign from_index_o    = from_q;
  assign to_index_o      = to_q;
  assign indices_valid_o = valid_q;
  assign alpha_o         = alpha_q;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for vector_keyframe_sampler.
// Loads keyframe tables, samples them under random idling and compares each result
// with a built-in predictor. Depends on vks_pkg and the block itself.
`timescale 1ns / 100ps

module tb_top;
  import vks_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainWait  = 60;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic        func;
    logic [7:0]  key_index;
    logic [31:0] key_time;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] sample_time;
  } item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  from_idx;
    logic [7:0]  to_idx;
    logic        valid;
    logic [16:0] alpha;
  } sample_t;

  logic clk_i, rst_ni;
  logic in_valid, in_ready;
  item_t drv;
  logic cfg_valid, cfg_ready;
  logic [8:0] cfg_data;
  logic out_valid, out_ready;
  sample_t got;

  // Block instance.
  vector_keyframe_sampler dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(drv.func), .key_index_i(drv.key_index), .key_time_i(drv.key_time),
    .value_x_i(drv.vx), .value_y_i(drv.vy), .value_z_i(drv.vz),
    .sample_time_i(drv.sample_time),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_x_o(got.x), .out_y_o(got.y), .out_z_o(got.z),
    .from_index_o(got.from_idx), .to_index_o(got.to_idx),
    .indices_valid_o(got.valid), .alpha_o(got.alpha)
  );

  // Clock and reset.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: key table and key count.
  logic [31:0] table_time [MaxKeys];
  logic [95:0] table_vec  [MaxKeys];
  logic [8:0]  pred_count;

  item_t   pending_items[$];
  sample_t expected_samples[$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned mismatches;
  int unsigned hold_req, hold_seen, hold_cnt;
  int unsigned quiet_cycles;

  // Interpolates one component: a + round((b - a) * alpha / 65536).
  function automatic logic [31:0] lerp_comp(logic [31:0] a, logic [31:0] b,
                                             logic [16:0] alpha);
    logic signed [63:0] va, vb, p, r;
    va = {{32{a[31]}}, a};
    vb = {{32{b[31]}}, b};
    p  = (vb - va) * $signed({47'd0, alpha});
    r  = va + ((p + 64'sd32768) >>> 16);
    return r[31:0];
  endfunction

  // Computes the expected sample for query time t from the current table.
  function automatic sample_t predict_sample(logic [31:0] t);
    sample_t r;
    int unsigned n, lo, cnt, stp, prb, ia, ib;
    logic [63:0] num, range, q;
    logic [16:0] al;
    n = (pred_count > MaxKeys) ? MaxKeys : pred_count;
    r = '0;
    if (n == 0) return r;
    r.valid = 1'b1;
    if (n == 1 || t <= table_time[0]) begin
      {r.x, r.y, r.z} = table_vec[0];
      return r;
    end
    lo  = 1;
    cnt = n - 1;
    while (cnt > 0) begin
      stp = cnt / 2;
      prb = lo + stp;
      if (table_time[prb] < t) begin
        lo  = prb + 1;
        cnt = cnt - (stp + 1);
      end else begin
        cnt = stp;
      end
    end
    if (lo >= n) begin
      {r.x, r.y, r.z} = table_vec[n-1];
      r.from_idx = 8'(n - 1);
      r.to_idx   = 8'(n - 1);
      return r;
    end
    ib = lo;
    ia = lo - 1;
    r.from_idx = 8'(ia);
    r.to_idx   = 8'(ib);
    if (table_time[ib] <= table_time[ia]) begin
      {r.x, r.y, r.z} = table_vec[ib];
      r.alpha = AlphaOne;
      return r;
    end
    num   = (t > table_time[ia]) ? 64'(t - table_time[ia]) : 64'd0;
    range = 64'(table_time[ib] - table_time[ia]);
    q     = (num << 16) / range;
    al    = (q > 64'h10000) ? AlphaOne : q[16:0];
    r.alpha = al;
    r.x = lerp_comp(table_vec[ia][95:64], table_vec[ib][95:64], al);
    r.y = lerp_comp(table_vec[ia][63:32], table_vec[ib][63:32], al);
    r.z = lerp_comp(table_vec[ia][31:0],  table_vec[ib][31:0],  al);
    return r;
  endfunction

  // Driver: offers queued items and updates the predictor on each transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      drv      <= '0;
    end else begin
      if (in_valid && in_ready) begin
        if (drv.func == FuncLoad) begin
          table_time[drv.key_index] = drv.key_time;
          table_vec[drv.key_index]  = {drv.vx, drv.vy, drv.vz};
        end else begin
          expected_samples.push_back(predict_sample(drv.sample_time));
        end
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv      <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, a long hold-off on request, and result checking.
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t exp_s;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
      hold_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_s = expected_samples.pop_front();
          if (got !== exp_s) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: x %h/%h y %h/%h z %h/%h from %0d/%0d to %0d/%0d v %b/%b a %h/%h",
                       exp_s.x, got.x, exp_s.y, got.y, exp_s.z, got.z,
                       exp_s.from_idx, got.from_idx, exp_s.to_idx, got.to_idx,
                       exp_s.valid, got.valid, exp_s.alpha, got.alpha);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_cnt  <= HoldCycles;
        out_ready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus generator state: which entries are written and their times.
  logic        gen_written [MaxKeys];
  logic [31:0] gen_time    [MaxKeys];

  function automatic item_t load_item(int unsigned idx, logic [31:0] kt);
    item_t it;
    it.func        = FuncLoad;
    it.key_index   = 8'(idx);
    it.key_time    = kt;
    it.vx          = $urandom;
    it.vy          = $urandom;
    it.vz          = $urandom;
    it.sample_time = $urandom;
    return it;
  endfunction

  task automatic push_sample(logic [31:0] t);
    item_t it;
    it = load_item($urandom_range(255), $urandom);
    it.func = FuncSample;
    it.sample_time = t;
    pending_items.push_back(it);
  endtask

  // Loads entries 0..n-1 with sorted times (or unsorted when scrambled).
  task automatic build_table(int unsigned n, bit scrambled, bit dup_heavy);
    logic [31:0] t, step_max;
    t = $urandom_range(1000);
    step_max = 32'hFFF0_0000 / (n + 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (scrambled) t = $urandom;
      else if (i != 0 && !(dup_heavy && $urandom_range(2) == 0))
        t = t + $urandom_range(step_max);
      gen_time[i]    = t;
      gen_written[i] = 1'b1;
      pending_items.push_back(load_item(i, t));
    end
  endtask

  // Random query times, biased toward the keys and the table edges.
  task automatic push_samples(int unsigned n, int unsigned num);
    int unsigned k, m;
    m = (n > MaxKeys) ? MaxKeys : n;
    for (int unsigned i = 0; i < num; i++) begin
      k = (m == 0) ? 0 : $urandom_range(m - 1);
      case ($urandom_range(7))
        0: push_sample($urandom);
        1: push_sample(gen_time[k]);
        2: push_sample(gen_time[k] + $urandom_range(3));
        3: push_sample(gen_time[k] - $urandom_range(3));
        4: push_sample($urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF);
        default: push_sample(gen_time[k] + $urandom_range(32'h0100_0000));
      endcase
    end
  endtask

  task automatic write_count(logic [8:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    pred_count = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    wait (pending_items.size() == 0 && !in_valid && expected_samples.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Phase list: key counts, extremes included.
  int unsigned counts [16] = '{0, 1, 2, 256, 511, 3, 4, 17, 9, 100, 255, 6, 40, 2, 257, 12};

  initial begin
    int unsigned n, m;
    in_valid = 1'b0;
    drv = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_ready = 1'b0;
    pred_count = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    hold_req = 0;
    quiet_cycles = 0;
    for (int i = 0; i < MaxKeys; i++) begin
      gen_written[i] = 1'b0;
      gen_time[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table straight after reset: samples need no loaded entries.
    push_sample(32'h0);
    push_sample(32'hFFFF_FFFF);
    push_sample($urandom);
    drain();

    for (int p = 0; p < 16; p++) begin
      n = counts[p];
      m = (n > MaxKeys) ? MaxKeys : n;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      write_count(9'(n));
      // Reload the table if its last used entry is unwritten, if it has under 60 entries, or in phase 3.
      if (m > 0 && (!gen_written[m-1] || m < 60 || p == 3))
        build_table(m, (p == 8 || p == 13), (p == 2 || p == 6 || p == 11));
      if (p == 3) hold_req = hold_req + 1;
      // Directed edge queries, then random ones.
      push_sample(32'h0);
      push_sample(32'hFFFF_FFFF);
      if (m > 0) begin
        push_sample(gen_time[0]);
        push_sample(gen_time[m-1]);
      end
      push_samples(n, (p == 3) ? 60 : 25);
      drain();
    end

    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
